// ===== hw/rtl/tmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtc_pkg
// Types and constants shared by the tempo map tick/time converter.
// ----------------------------------------------------------------------------
package tmtc_pkg;

   localparam int TICK_W  = 31;
   localparam int TEMPO_W = 20;
   localparam int TIME_W  = 56;
   localparam int TPQ_W   = 16;
   localparam int STAT_W  = 3;
   localparam int ACT_W   = 2;

   // multiply/divide unit operand widths
   localparam int MA_W   = 56;
   localparam int MB_W   = 42;
   localparam int PROD_W = MA_W + MB_W;
   localparam int QUO_W  = PROD_W + 1;
   localparam int MDC_W  = 7;

   // 60000 ms per minute * 1000 (milli-BPM) * 65536 (Q.16)
   localparam logic [MB_W-1:0]    MS_SCALE      = 42'd3932160000000;
   localparam logic [MB_W-1:0]    MS_HALF       = 42'd1966080000000;
   localparam logic [TEMPO_W-1:0] TEMPO_TOP     = 20'd1000000;
   localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 20'd120000;
   localparam logic [TPQ_W-1:0]   DEFAULT_TPQ   = 16'd480;

   // actions
   localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_T2TIME = 2'd2;
   localparam logic [ACT_W-1:0] ACT_TIME2T = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_TEMPO = 3'd4;

   typedef struct packed {
      logic [TICK_W-1:0]  tick;
      logic [TEMPO_W-1:0] tempo;
      logic [TIME_W-1:0]  start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // request to the multiply/divide unit: (a * b + add) / den
   typedef struct packed {
      logic            div_en;
      logic [MA_W-1:0] a;
      logic [MB_W-1:0] b;
      logic [MB_W-1:0] add;
      logic [MB_W-1:0] den;
   } md_req_type;

endpackage

// ===== hw/rtl/tmtc_ram.sv =====
// ----------------------------------------------------------------------------
// tmtc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tmtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/tmtc_muldiv.sv =====
// ----------------------------------------------------------------------------
// tmtc_muldiv
// Serial shift-add multiplier followed by an optional restoring divider:
// computes a*b, and (a*b + add) / den when div_en is set.
// ----------------------------------------------------------------------------
module tmtc_muldiv (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  tmtc_pkg::md_req_type              req,
   output logic                              done,
   output logic [tmtc_pkg::PROD_W-1:0]       prod,
   output logic [tmtc_pkg::QUO_W-1:0]        quot
);

   localparam logic [1:0] MD_IDLE = 2'd0;
   localparam logic [1:0] MD_MUL  = 2'd1;
   localparam logic [1:0] MD_DIV  = 2'd2;

   localparam int MA_W = tmtc_pkg::MA_W;
   localparam int MB_W = tmtc_pkg::MB_W;

   logic [1:0]                      state_ff, state_in;
   logic [tmtc_pkg::MDC_W-1:0]      cnt_ff, cnt_in;
   logic                            done_ff, done_in;
   tmtc_pkg::md_req_type            req_ff, req_in;
   logic [tmtc_pkg::PROD_W-1:0]     prod_ff, prod_in, prod_step;
   logic [tmtc_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [MB_W-1:0]                 rem_ff, rem_in;
   logic [MB_W:0]                   mul_sum;
   logic [MB_W:0]                   rem_sh;
   logic [MB_W:0]                   rem_sub;
   logic                            rem_ge;

   // one multiplier bit per step, one quotient bit per step
   always_comb begin
      mul_sum   = {1'b0, prod_ff[tmtc_pkg::PROD_W-1:MA_W]} +
                  (prod_ff[0] ? {1'b0, req_ff.b} : {(MB_W+1){1'b0}});
      prod_step = {mul_sum, prod_ff[MA_W-1:1]};
      rem_sh    = {rem_ff, quo_ff[tmtc_pkg::QUO_W-1]};
      rem_sub   = rem_sh - {1'b0, req_ff.den};
      rem_ge    = (rem_sh >= {1'b0, req_ff.den});
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      req_in   = req_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               req_in   = req;
               prod_in  = {{MB_W{1'b0}}, req.a};
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = prod_step;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == tmtc_pkg::MDC_W'(MA_W - 1)) begin
               cnt_in = '0;
               if (req_ff.div_en) begin
                  quo_in   = {1'b0, prod_step} +
                             {{(tmtc_pkg::QUO_W-MB_W){1'b0}}, req_ff.add};
                  rem_in   = '0;
                  state_in = MD_DIV;
               end else begin
                  done_in  = 1'b1;
                  state_in = MD_IDLE;
               end
            end
         end
         MD_DIV: begin
            rem_in = rem_ge ? rem_sub[MB_W-1:0] : rem_sh[MB_W-1:0];
            quo_in = {quo_ff[tmtc_pkg::QUO_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tmtc_pkg::MDC_W'(tmtc_pkg::QUO_W - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      req_ff  <= req_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
   assign quot = quo_ff;

endmodule

// ===== hw/rtl/tempo_map_tick_time_converter_unit.sv =====
// ----------------------------------------------------------------------------
// tempo_map_tick_time_converter_unit
// Tempo map with tick <-> time conversion over a tick-sorted tempo table.
// ----------------------------------------------------------------------------
// The tempo table (tick, milli-BPM tempo, Q.16 ms start time) lives in one
// RAM of MAX_TEMPOS entries. After reset the block writes the default entry
// (tick 0, 120 BPM) before it takes beats. One item is handled at a time.
// Every request but a SET with a bad tempo first scans the table, one entry
// at a time. A conversion then runs one multiply and one multiply-divide in
// the shared serial arithmetic unit. Edits shift entries one by one and then
// rebuild start times from the first changed entry, one entry at a time, each
// with a multiply and a multiply-divide in the same unit.
// A ticks_per_quarter write rebuilds every start time the same way; csr_ready
// is low while the block is busy. A result waiting in the output register
// does not stop the next request from being taken.
// ----------------------------------------------------------------------------
module tempo_map_tick_time_converter_unit #(
   parameter int MAX_TEMPOS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tmtc_pkg::ACT_W-1:0]          req_action,
   input  logic [tmtc_pkg::TICK_W-1:0]         req_tick_position,
   input  logic [tmtc_pkg::TEMPO_W-1:0]        req_tempo_milli_bpm,
   input  logic [tmtc_pkg::TIME_W-1:0]         req_time_q16,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tmtc_pkg::STAT_W-1:0]         rsp_status,
   output logic [tmtc_pkg::TICK_W-1:0]         rsp_result_tick,
   output logic [tmtc_pkg::TIME_W-1:0]         rsp_result_time_q16,
   output logic [tmtc_pkg::TICK_W-1:0]         rsp_segment_tick,
   output logic [tmtc_pkg::TEMPO_W-1:0]        rsp_segment_tempo,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmtc_pkg::TPQ_W-1:0]          csr_data
);

   localparam int AW = (MAX_TEMPOS > 1) ? $clog2(MAX_TEMPOS) : 1;
   localparam int CW = $clog2(MAX_TEMPOS + 1);

   localparam int TICK_W  = tmtc_pkg::TICK_W;
   localparam int TEMPO_W = tmtc_pkg::TEMPO_W;
   localparam int TIME_W  = tmtc_pkg::TIME_W;
   localparam int TPQ_W   = tmtc_pkg::TPQ_W;
   localparam int MA_W    = tmtc_pkg::MA_W;
   localparam int MB_W    = tmtc_pkg::MB_W;
   localparam int QUO_W   = tmtc_pkg::QUO_W;
   localparam int DEN_W   = TPQ_W + TEMPO_W;

   // sequencer states
   localparam logic [4:0] S_INIT   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_SC_RD  = 5'd2;
   localparam logic [4:0] S_SC_CHK = 5'd3;
   localparam logic [4:0] S_DISP   = 5'd4;
   localparam logic [4:0] S_SH_RD  = 5'd5;
   localparam logic [4:0] S_SH_WR  = 5'd6;
   localparam logic [4:0] S_INS_WR = 5'd7;
   localparam logic [4:0] S_RM_RD  = 5'd8;
   localparam logic [4:0] S_RM_WR  = 5'd9;
   localparam logic [4:0] S_RB_BEG = 5'd10;
   localparam logic [4:0] S_RB_CPP = 5'd11;
   localparam logic [4:0] S_RB_RD  = 5'd12;
   localparam logic [4:0] S_RB_CAP = 5'd13;
   localparam logic [4:0] S_DGO    = 5'd14;
   localparam logic [4:0] S_DW     = 5'd15;
   localparam logic [4:0] S_SGO    = 5'd16;
   localparam logic [4:0] S_SW     = 5'd17;
   localparam logic [4:0] S_DONE   = 5'd18;

   logic [4:0]                 state_ff, state_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [TPQ_W-1:0]           tpq_ff, tpq_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              from_ff, from_in;
   logic [AW-1:0]              k_ff, k_in;
   logic                       rb_ff, rb_in;
   logic                       cfg_ff, cfg_in;
   logic [tmtc_pkg::STAT_W-1:0] stat_ff, stat_in;

   // captured request
   logic [tmtc_pkg::ACT_W-1:0] act_ff, act_in;
   logic [TICK_W-1:0]          tick_ff, tick_in;
   logic [TEMPO_W-1:0]         tempo_ff, tempo_in;
   logic [TIME_W-1:0]          time_ff, time_in;

   tmtc_pkg::entry_type        ke_ff, ke_in;     // segment entry
   tmtc_pkg::entry_type        pe_ff, pe_in;     // previous entry (rebuild)
   tmtc_pkg::entry_type        ce_ff, ce_in;     // current entry (rebuild)
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [TICK_W-1:0]          rtick_ff, rtick_in;
   logic [TIME_W-1:0]          rtime_ff, rtime_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tmtc_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TICK_W-1:0]          rsp_rtick_ff, rsp_rtick_in;
   logic [TIME_W-1:0]          rsp_rtime_ff, rsp_rtime_in;
   logic [TICK_W-1:0]          rsp_stick_ff, rsp_stick_in;
   logic [TEMPO_W-1:0]         rsp_stempo_ff, rsp_stempo_in;

   // RAM port
   logic                       ram_we;
   logic [AW-1:0]              ram_wa;
   tmtc_pkg::entry_type        ram_wd;
   logic [AW-1:0]              ram_ra;
   tmtc_pkg::entry_type        ram_rd;

   // arithmetic unit
   logic                       md_start;
   tmtc_pkg::md_req_type       md_req;
   logic                       md_done;
   logic [tmtc_pkg::PROD_W-1:0] md_prod;
   logic [QUO_W-1:0]           md_quot;

   logic                       req_fire, csr_fire, rsp_fire;
   logic [TPQ_W-1:0]           eff_tpq;
   logic                       scan_hit;
   logic [CW-1:0]              k_ext;
   logic [CW-1:0]              rb_from;
   logic [TIME_W-1:0]          span_sat;
   logic [TIME_W:0]            start_sum;
   logic [TIME_W-1:0]          start_sat;
   logic [TICK_W-1:0]          qtick_sat;
   logic [TICK_W:0]            tick_sum;

   tmtc_ram #(
      .WIDTH (tmtc_pkg::ENTRY_W),
      .DEPTH (MAX_TEMPOS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   tmtc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .req   (md_req),
      .done  (md_done),
      .prod  (md_prod),
      .quot  (md_quot)
   );

   // handshakes
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // shared datapath terms
   always_comb begin
      eff_tpq   = (tpq_ff == '0) ? TPQ_W'(1) : tpq_ff;
      k_ext     = CW'(k_ff);
      rb_from   = (from_ff == '0) ? CW'(1) : from_ff;
      scan_hit  = (idx_ff == '0) ||
                  ((act_ff == tmtc_pkg::ACT_TIME2T) ? (ram_rd.start <= time_ff)
                                                     : (ram_rd.tick <= tick_ff));
      span_sat  = (|md_quot[QUO_W-1:TIME_W]) ? {TIME_W{1'b1}} : md_quot[TIME_W-1:0];
      start_sum = {1'b0, (rb_ff ? pe_ff.start : ke_ff.start)} + {1'b0, span_sat};
      start_sat = start_sum[TIME_W] ? {TIME_W{1'b1}} : start_sum[TIME_W-1:0];
      qtick_sat = (|md_quot[QUO_W-1:TICK_W]) ? {TICK_W{1'b1}} : md_quot[TICK_W-1:0];
      tick_sum  = {1'b0, ke_ff.tick} + {1'b0, qtick_sat};
   end

   // arithmetic requests: denominator first, then span or tick quotient
   always_comb begin
      md_req        = '0;
      md_req.div_en = (state_ff == S_SGO);
      if (state_ff == S_DGO) begin
         md_req.a = MA_W'(eff_tpq);
         md_req.b = MB_W'(rb_ff ? pe_ff.tempo : ke_ff.tempo);
      end else if (rb_ff) begin
         md_req.a   = MA_W'(ce_ff.tick - pe_ff.tick);
         md_req.b   = tmtc_pkg::MS_SCALE;
         md_req.add = MB_W'(den_ff >> 1);
         md_req.den = MB_W'(den_ff);
      end else if (act_ff == tmtc_pkg::ACT_T2TIME) begin
         md_req.a   = MA_W'(tick_ff - ke_ff.tick);
         md_req.b   = tmtc_pkg::MS_SCALE;
         md_req.add = MB_W'(den_ff >> 1);
         md_req.den = MB_W'(den_ff);
      end else begin
         md_req.a   = time_ff - ke_ff.start;
         md_req.b   = MB_W'(den_ff);
         md_req.add = tmtc_pkg::MS_HALF;
         md_req.den = tmtc_pkg::MS_SCALE;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      tpq_in   = tpq_ff;
      idx_in   = idx_ff;
      from_in  = from_ff;
      k_in     = k_ff;
      rb_in    = rb_ff;
      cfg_in   = cfg_ff;
      stat_in  = stat_ff;
      act_in   = act_ff;
      tick_in  = tick_ff;
      tempo_in = tempo_ff;
      time_in  = time_ff;
      ke_in    = ke_ff;
      pe_in    = pe_ff;
      ce_in    = ce_ff;
      den_in   = den_ff;
      rtick_in = rtick_ff;
      rtime_in = rtime_ff;
      ram_we   = 1'b0;
      ram_wa   = '0;
      ram_wd   = '0;
      ram_ra   = '0;
      md_start = 1'b0;

      case (state_ff)
         S_INIT: begin
            ram_we       = 1'b1;
            ram_wd.tempo = tmtc_pkg::DEFAULT_TEMPO;
            cnt_in       = CW'(1);
            state_in     = S_IDLE;
         end
         S_IDLE: begin
            if (csr_fire) begin
               tpq_in   = csr_data;
               from_in  = CW'(1);
               cfg_in   = 1'b1;
               state_in = S_RB_BEG;
            end else if (req_fire) begin
               act_in   = req_action;
               tick_in  = req_tick_position;
               tempo_in = req_tempo_milli_bpm;
               time_in  = req_time_q16;
               cfg_in   = 1'b0;
               rb_in    = 1'b0;
               stat_in  = tmtc_pkg::ST_OK;
               rtick_in = '0;
               rtime_in = '0;
               idx_in   = '0;
               k_in     = '0;
               if (req_action == tmtc_pkg::ACT_SET &&
                   (req_tempo_milli_bpm == '0 ||
                    req_tempo_milli_bpm > tmtc_pkg::TEMPO_TOP)) begin
                  stat_in  = tmtc_pkg::ST_BAD_TEMPO;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SC_RD;
               end
            end
         end
         // segment search: read an entry, then check it
         S_SC_RD: begin
            ram_ra   = idx_ff[AW-1:0];
            state_in = S_SC_CHK;
         end
         S_SC_CHK: begin
            if (scan_hit) begin
               k_in  = idx_ff[AW-1:0];
               ke_in = ram_rd;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == cnt_ff) ? S_DISP : S_SC_RD;
         end
         S_DISP: begin
            case (act_ff)
               tmtc_pkg::ACT_SET: begin
                  if (ke_ff.tick == tick_ff) begin
                     if (ke_ff.tempo == tempo_ff) begin
                        stat_in  = tmtc_pkg::ST_UNCHANGED;
                        state_in = S_DONE;
                     end else begin
                        ram_we       = 1'b1;
                        ram_wa       = k_ff;
                        ram_wd       = ke_ff;
                        ram_wd.tempo = tempo_ff;
                        from_in      = k_ext;
                        state_in     = S_RB_BEG;
                     end
                  end else if (cnt_ff == CW'(MAX_TEMPOS)) begin
                     stat_in  = tmtc_pkg::ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = (cnt_ff > k_ext + 1'b1) ? S_SH_RD : S_INS_WR;
                  end
               end
               tmtc_pkg::ACT_REMOVE: begin
                  if (tick_ff == '0 || ke_ff.tick != tick_ff) begin
                     stat_in  = tmtc_pkg::ST_NOT_FOUND;
                     state_in = S_DONE;
                  end else if (k_ext + 1'b1 < cnt_ff) begin
                     idx_in   = k_ext;
                     state_in = S_RM_RD;
                  end else begin
                     cnt_in   = cnt_ff - 1'b1;
                     from_in  = k_ext;
                     state_in = S_RB_BEG;
                  end
               end
               default: begin
                  state_in = S_DGO;
               end
            endcase
         end
         // open a slot: move entries up by one, top first
         S_SH_RD: begin
            ram_ra   = AW'(idx_ff - 1'b1);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            ram_we   = 1'b1;
            ram_wa   = idx_ff[AW-1:0];
            ram_wd   = ram_rd;
            idx_in   = idx_ff - 1'b1;
            state_in = (idx_ff - 1'b1 > k_ext + 1'b1) ? S_SH_RD : S_INS_WR;
         end
         S_INS_WR: begin
            ram_we       = 1'b1;
            ram_wa       = AW'(k_ext + 1'b1);
            ram_wd.tick  = tick_ff;
            ram_wd.tempo = tempo_ff;
            cnt_in       = cnt_ff + 1'b1;
            from_in      = k_ext + 1'b1;
            state_in     = S_RB_BEG;
         end
         // close a slot: move entries down by one
         S_RM_RD: begin
            ram_ra   = AW'(idx_ff + 1'b1);
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[AW-1:0];
            ram_wd = ram_rd;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 2'd2 < cnt_ff) begin
               state_in = S_RM_RD;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               from_in  = k_ext;
               state_in = S_RB_BEG;
            end
         end
         // start time rebuild
         S_RB_BEG: begin
            rb_in = 1'b1;
            if (rb_from >= cnt_ff) begin
               rb_in    = 1'b0;
               state_in = cfg_ff ? S_IDLE : S_DONE;
            end else begin
               idx_in   = rb_from;
               ram_ra   = AW'(rb_from - 1'b1);
               state_in = S_RB_CPP;
            end
         end
         S_RB_CPP: begin
            pe_in    = ram_rd;
            state_in = S_RB_RD;
         end
         S_RB_RD: begin
            ram_ra   = idx_ff[AW-1:0];
            state_in = S_RB_CAP;
         end
         S_RB_CAP: begin
            ce_in    = ram_rd;
            state_in = S_DGO;
         end
         // denominator tpq * tempo
         S_DGO: begin
            md_start = 1'b1;
            state_in = S_DW;
         end
         S_DW: begin
            if (md_done) begin
               den_in   = md_prod[DEN_W-1:0];
               state_in = S_SGO;
            end
         end
         S_SGO: begin
            md_start = 1'b1;
            state_in = S_SW;
         end
         S_SW: begin
            if (md_done) begin
               if (rb_ff) begin
                  ram_we      = 1'b1;
                  ram_wa      = idx_ff[AW-1:0];
                  ram_wd      = ce_ff;
                  ram_wd.start = start_sat;
                  pe_in       = ce_ff;
                  pe_in.start = start_sat;
                  idx_in      = idx_ff + 1'b1;
                  if (idx_ff + 1'b1 < cnt_ff) begin
                     state_in = S_RB_RD;
                  end else begin
                     rb_in    = 1'b0;
                     state_in = cfg_ff ? S_IDLE : S_DONE;
                  end
               end else if (act_ff == tmtc_pkg::ACT_T2TIME) begin
                  rtime_in = start_sat;
                  state_in = S_DONE;
               end else begin
                  rtick_in = tick_sum[TICK_W] ? {TICK_W{1'b1}} : tick_sum[TICK_W-1:0];
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rtick_in  = rsp_rtick_ff;
      rsp_rtime_in  = rsp_rtime_ff;
      rsp_stick_in  = rsp_stick_ff;
      rsp_stempo_in = rsp_stempo_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = stat_ff;
         rsp_rtick_in  = rtick_ff;
         rsp_rtime_in  = rtime_ff;
         rsp_stick_in  = act_ff[1] ? ke_ff.tick : '0;
         rsp_stempo_in = act_ff[1] ? ke_ff.tempo : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         tpq_ff       <= tmtc_pkg::DEFAULT_TPQ;
         rb_ff        <= 1'b0;
         cfg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tpq_ff       <= tpq_in;
         rb_ff        <= rb_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      from_ff       <= from_in;
      k_ff          <= k_in;
      stat_ff       <= stat_in;
      act_ff        <= act_in;
      tick_ff       <= tick_in;
      tempo_ff      <= tempo_in;
      time_ff       <= time_in;
      ke_ff         <= ke_in;
      pe_ff         <= pe_in;
      ce_ff         <= ce_in;
      den_ff        <= den_in;
      rtick_ff      <= rtick_in;
      rtime_ff      <= rtime_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rtick_ff  <= rsp_rtick_in;
      rsp_rtime_ff  <= rsp_rtime_in;
      rsp_stick_ff  <= rsp_stick_in;
      rsp_stempo_ff <= rsp_stempo_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_tick     = rsp_rtick_ff;
   assign rsp_result_time_q16 = rsp_rtime_ff;
   assign rsp_segment_tick    = rsp_stick_ff;
   assign rsp_segment_tempo   = rsp_stempo_ff;

   // table occupancy stays within 1..MAX_TEMPOS once initialized
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |-> (cnt_ff != '0 && cnt_ff <= CW'(MAX_TEMPOS)))
      else $error("entry count out of range");

   // a response beat is only launched from the completion state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

   // table writes land at most one slot past the last entry
   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CW'(ram_wa) <= cnt_ff))
      else $error("table write beyond entry count");

   // each arithmetic start is followed by one of the wait states
   a_md_start: assert property (@(posedge clock) disable iff (reset)
      md_start |=> (state_ff == S_DW || state_ff == S_SW))
      else $error("arithmetic start without wait");

endmodule
